>>> rtl/assert_macros.svh
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge outside reset
`define CHK_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

>>> rtl/rbfk_pkg.sv
// package for the rbf kernel row engine: widths, constants, exp table
// no dependencies
`timescale 1ns / 1ps
package rbfk_pkg;
  localparam int DefMaxCenters  = 32;
  localparam int DefMaxFeatures = 64;
  localparam int DefFeatureBits = 16;
  localparam int AccW   = 48;
  localparam int GammaW = 24;
  localparam int CountW = 6;
  localparam int SlotW  = 5;
  localparam int FidxW  = 6;
  localparam int KernW  = 16;
  localparam int ExpBits = 20;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;
  localparam logic REG_GAMMA = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  typedef struct packed {
    logic             vld;
    logic [SlotW-1:0] num;
    logic [AccW-1:0]  dsum;
    logic             last;
  } drain_t;

  function automatic logic [29:0] exp_tab(input logic [4:0] k);
    logic [29:0] r;
    case (k)
      5'd0:  r = 30'd1073725440;
      5'd1:  r = 30'd1073709056;
      5'd2:  r = 30'd1073676290;
      5'd3:  r = 30'd1073610760;
      5'd4:  r = 30'd1073479712;
      5'd5:  r = 30'd1073217664;
      5'd6:  r = 30'd1072693760;
      5'd7:  r = 30'd1071646719;
      5'd8:  r = 30'd1069555701;
      5'd9:  r = 30'd1065385899;
      5'd10: r = 30'd1057095000;
      5'd11: r = 30'd1040706261;
      5'd12: r = 30'd1008687096;
      5'd13: r = 30'd947573834;
      5'd14: r = 30'd836230973;
      5'd15: r = 30'd651257337;
      5'd16: r = 30'd395007542;
      5'd17: r = 30'd145315154;
      5'd18: r = 30'd19666268;
      5'd19: r = 30'd360200;
      default: r = 30'd0;
    endcase
    return r;
  endfunction
endpackage

>>> rtl/rbfk_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
module rbfk_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/rbfk_cell.sv
// one center cell: feature memory, squared difference, saturating accumulator
// depends on rbfk_pkg, rbfk_ram
`timescale 1ns / 1ps
module rbfk_cell
  import rbfk_pkg::*;
#(
  parameter int MAX_FEATURES = DefMaxFeatures,
  parameter int FEATURE_BITS = DefFeatureBits
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ld_we,
  input  logic [$clog2(MAX_FEATURES)-1:0] faddr,
  input  logic [FEATURE_BITS-1:0]         ld_val,
  // stage 1 (data read issued last cycle)
  input  logic                            acc_en,
  input  logic signed [FEATURE_BITS-1:0]  x_s1,
  input  logic                            clr,
  // drain chain: capture own distance, shift from upstream
  input  logic                            cap,
  input  logic [SlotW-1:0]                my_num,
  input  logic                            my_last,
  input  logic                            my_use,
  input  drain_t                          dr_in,
  output drain_t                          dr_out
);
  localparam int DW = FEATURE_BITS + 1;
  logic [FEATURE_BITS-1:0] c_rd;
  logic [AccW-1:0] acc_r, acc_nxt;
  logic [DW-1:0] mag;
  logic signed [DW-1:0] diff;
  logic [AccW-1:0] sq;
  logic [AccW:0] sum;
  drain_t dr_r, dr_nxt;

  rbfk_ram #(.WIDTH(FEATURE_BITS), .DEPTH(MAX_FEATURES)) u_mem (
    .clk(clk), .we(ld_we), .waddr(faddr), .wdata(ld_val), .raddr(faddr), .rdata(c_rd)
  );

  always_comb begin
    diff = DW'(x_s1) - DW'($signed(c_rd));
    mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
    if (DW > 24 && (mag >> 24) != '0) sq = AccMax;
    else sq = AccW'(mag) * AccW'(mag);
    sum = {1'b0, acc_r} + {1'b0, sq};
    acc_nxt = acc_r;
    if (acc_en) acc_nxt = (sum[AccW] || sq == AccMax) ? AccMax : sum[AccW-1:0];
    if (clr) acc_nxt = '0;
    if (cap) begin
      dr_nxt.vld = my_use; dr_nxt.num = my_num;
      dr_nxt.dsum = acc_r; dr_nxt.last = my_last;
    end else dr_nxt = dr_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      dr_r  <= '0;
    end else begin
      acc_r <= acc_nxt;
      dr_r  <= dr_nxt;
    end
  end
  assign dr_out = dr_r;
endmodule

>>> rtl/rbfk_exp.sv
// kernel unit: gamma * distance then bit-serial table exponential
// depends on rbfk_pkg
`timescale 1ns / 1ps
module rbfk_exp
  import rbfk_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [AccW-1:0]   dsum,
  input  logic [GammaW-1:0] gamma,
  input  logic [SlotW-1:0]  num_in,
  input  logic              last_in,
  output logic              busy,
  output logic              done,
  output logic [SlotW-1:0]  num_out,
  output logic [KernW-1:0]  kern,
  output logic              last_out
);
  localparam logic [1:0] S_IDLE = 2'd0, S_MUL = 2'd1, S_EXP = 2'd2, S_OUT = 2'd3;
  logic [1:0] st_r;
  logic [AccW-1:0] d_r;
  logic [GammaW-1:0] g_r;
  logic [47:0] ph_r, pl_r;
  logic [4:0] k_r;
  logic [ExpBits-1:0] x_r;
  logic [30:0] p_r;
  logic [SlotW-1:0] n_r;
  logic l_r, big_r;
  logic [64:0] xw;
  logic [61:0] prod;
  logic [30:0] pn;

  always_comb begin
    xw = 65'(ph_r) + 65'(pl_r >> 24);
    prod = 62'(p_r) * 62'(exp_tab(k_r)) + (62'(1) << 29);
    pn = 31'(prod >> 30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      case (st_r)
        S_IDLE: if (go) begin
          d_r <= dsum; g_r <= gamma; n_r <= num_in; l_r <= last_in; st_r <= S_MUL;
        end
        S_MUL: begin
          ph_r <= 48'(g_r) * 48'(d_r[AccW-1:24]);
          pl_r <= 48'(g_r) * 48'(d_r[23:0]);
          k_r  <= '0; p_r <= 31'(1) << 30;
          st_r <= S_EXP; big_r <= 1'b1;
        end
        S_EXP: begin
          if (big_r) begin
            big_r <= (xw >> ExpBits) != '0;
            x_r   <= xw[ExpBits-1:0];
            if ((xw >> ExpBits) != '0) st_r <= S_OUT;
          end else begin
            if (x_r[k_r]) p_r <= pn;
            k_r <= k_r + 5'd1;
            if (k_r == 5'(ExpBits - 1)) st_r <= S_OUT;
          end
        end
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
  // big_r stays high into S_OUT only on overflow
  logic [31:0] kr;
  assign kr = 32'(p_r) + 32'(1 << 14);
  assign busy = st_r != S_IDLE;
  assign done = st_r == S_OUT;
  assign num_out = n_r;
  assign last_out = l_r;
  assign kern = big_r ? '0 : KernW'(kr >> 15);
endmodule

>>> rtl/rbf_kernel_row_engine.sv
// top level of the gaussian rbf kernel row engine
// depends on rbfk_pkg, rbfk_cell, rbfk_exp, rbfk_ram, assert_macros.svh
`timescale 1ns / 1ps
// usage:
//   in_ channel: pulse start with command/slot/index/value/row_end while busy is low.
//   load beats (command 0) write one feature of one center; busy stays low.
//   data beats (command 1) add (x-c)^2 to every active center accumulator,
//   all cells in parallel; a data beat without row_end first reads the
//   center memories, then accumulates.
//   on row_end the cells capture their distances into a drain chain and clear;
//   the chain shifts one center per kernel result into the exp unit.
//   each kernel passes handoff, gamma multiply, range check, one table
//   step per exponent bit and output, skipping the table steps when the
//   exponent is past the table; a row end keeps busy high until the last
//   center's kernel is out; the bit-serial exp loop sets that time.
//   out_ channel: out_valid strobes one cycle per center, center 0 first,
//   out_last on the final center; the receiver cannot stall.
//   cfg_ channel: valid/ready write of gamma (0) or center_count (1),
//   always ready; write only while idle.
//   reset: synchronous active low; clears accumulators, gamma to 1.0,
//   count to 32; center memories are undefined until loaded.
`include "assert_macros.svh"
module rbf_kernel_row_engine
  import rbfk_pkg::*;
#(
  parameter int MAX_CENTERS  = DefMaxCenters,
  parameter int MAX_FEATURES = DefMaxFeatures,
  parameter int FEATURE_BITS = DefFeatureBits
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic                    in_command,
  input  logic [SlotW-1:0]        in_center_slot,
  input  logic [FidxW-1:0]        in_feature_index,
  input  logic signed [FEATURE_BITS-1:0] in_feature_value,
  input  logic                    in_row_end,
  output logic                    out_valid,
  output logic [SlotW-1:0]        out_center_number,
  output logic [KernW-1:0]        out_kernel_value,
  output logic                    out_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_index,
  input  logic [GammaW-1:0]       cfg_data
);
  localparam int FAW = $clog2(MAX_FEATURES);
  localparam logic [1:0] S_IDLE = 2'd0, S_ACC = 2'd1, S_CAP = 2'd2, S_DRAIN = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [GammaW-1:0] gamma_r;
  logic [CountW-1:0] count_r;
  logic [CountW-1:0] nuse;
  logic accept, in_range;
  logic [FAW-1:0] faddr;
  logic signed [FEATURE_BITS-1:0] x_r;
  logic fi_ok_r, rend_r;
  logic [CountW-1:0] nuse_r;
  drain_t chain [MAX_CENTERS+1];
  logic shift, cap;
  logic exp_busy, exp_done, exp_last;
  logic [SlotW-1:0] exp_num;
  logic [KernW-1:0] exp_kern;

  assign accept = start && !busy;
  assign busy = st_r != S_IDLE;
  assign cfg_ready = 1'b1;
  assign faddr = FAW'(in_feature_index);
  assign in_range = 32'(in_feature_index) < MAX_FEATURES;

  // count clamp: zero means one, above capacity means capacity
  always_comb begin
    if (count_r == '0) nuse = CountW'(1);
    else if (32'(count_r) > MAX_CENTERS) nuse = CountW'(MAX_CENTERS);
    else nuse = count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GammaW'(65536);
      count_r <= CountW'(32);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_GAMMA) gamma_r <= cfg_data;
      else count_r <= CountW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_feature_value;
      fi_ok_r <= in_range;
      rend_r <= in_row_end;
      nuse_r <= nuse;
    end
  end

  // head of the drain chain is empty
  assign chain[MAX_CENTERS] = '0;
  assign cap = st_r == S_CAP;
  assign shift = (st_r == S_DRAIN) && !exp_busy;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_CENTERS; gi++) begin : g_cell
      logic ld_we, use_c;
      assign ld_we = accept && in_command == CMD_LOAD && in_range
                     && 32'(in_center_slot) == gi;
      assign use_c = gi < 32'(nuse_r);
      rbfk_cell #(.MAX_FEATURES(MAX_FEATURES), .FEATURE_BITS(FEATURE_BITS)) u_cell (
        .clk(clk), .rst_n(rst_n), .ld_we(ld_we), .faddr(faddr),
        .ld_val(in_feature_value),
        .acc_en(st_r == S_ACC && fi_ok_r && use_c), .x_s1(x_r), .clr(cap),
        .cap(cap), .my_num(SlotW'(gi)), .my_last(gi == 32'(nuse_r) - 1),
        .my_use(use_c),
        .dr_in(shift ? chain[gi+1] : chain[gi]), .dr_out(chain[gi])
      );
    end
  endgenerate

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (accept && in_command == CMD_DATA) st_nxt = S_ACC;
      S_ACC: st_nxt = rend_r ? S_CAP : S_IDLE;
      S_CAP: st_nxt = S_DRAIN;
      S_DRAIN: if (exp_done && exp_last) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  rbfk_exp u_exp (
    .clk(clk), .rst_n(rst_n), .go(shift && chain[0].vld), .dsum(chain[0].dsum),
    .gamma(gamma_r), .num_in(chain[0].num), .last_in(chain[0].last),
    .busy(exp_busy), .done(exp_done), .num_out(exp_num), .kern(exp_kern),
    .last_out(exp_last)
  );

  assign out_valid = exp_done;
  assign out_center_number = exp_num;
  assign out_kernel_value = exp_kern;
  assign out_last = exp_last;

  `CHK_IMPL(a_out_in_drain, out_valid, st_r == S_DRAIN, "result outside drain")
  `CHK_IMPL(a_kern_range, out_valid, out_kernel_value <= 16'd32768, "kernel above one")
  `CHK_NEXT(a_busy_after_data, accept && in_command == CMD_DATA, busy, "data beat not held")
endmodule

>>> sim/rbf_kernel_row_engine_tb.sv
// self-checking testbench for rbf_kernel_row_engine: a directed table, then random
// load/data beats, with every kernel result compared against a behavioral predictor
// depends on rbfk_pkg and the rbf_kernel_row_engine rtl
`timescale 1ns / 1ps
module rbf_kernel_row_engine_tb
  import rbfk_pkg::*;
();

  localparam int NumCenters  = 32;
  localparam int NumFeatures = 64;
  localparam int DrainCycles = 50;    // settle time after the last kernel result
  localparam int StallLimit  = 5000;  // cycles without any handshake before giving up

  // round(exp(-2^(k-16)) * 2^30), one entry per exponent bit
  localparam logic [29:0] ExpStep [20] = '{
    30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760,
    30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
    30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
    30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
    30'd395007542,  30'd145315154,  30'd19666268,   30'd360200
  };

  typedef struct {
    logic              cmd;
    logic [SlotW-1:0]  slot;
    logic [FidxW-1:0]  fidx;
    logic signed [15:0] val;
    logic              rend;
    logic              typed;   // kernel value below is fixed by hand
    logic [KernW-1:0]  kv;
  } beat_t;

  typedef struct {
    logic [SlotW-1:0] num;
    logic [KernW-1:0] kv;
    logic             last;
  } kernel_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_command = CMD_LOAD;
  logic [SlotW-1:0] in_center_slot = '0;
  logic [FidxW-1:0] in_feature_index = '0;
  logic signed [15:0] in_feature_value = '0;
  logic in_row_end = 1'b0;
  logic out_valid;
  logic [SlotW-1:0] out_center_number;
  logic [KernW-1:0] out_kernel_value;
  logic out_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = REG_GAMMA;
  logic [GammaW-1:0] cfg_data = '0;

  rbf_kernel_row_engine DUT (.*);

  always #5 clk = ~clk;

  // predictor state
  logic [GammaW-1:0] gamma_q;
  logic [CountW-1:0] count_q;
  logic signed [15:0] center_mem [NumCenters][NumFeatures];
  bit loaded [NumCenters][NumFeatures];
  logic [AccW-1:0] dist_acc [NumCenters];
  kernel_res_t pending_kernels[$];

  int errors = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;  // no random gaps while set

  // ---------------- predictor ----------------

  function automatic int active_centers();
    if (count_q == 0) return 1;
    if (count_q > NumCenters) return NumCenters;
    return int'(count_q);
  endfunction

  // exp(-gamma*d) in q1.15 via the bit-serial table product
  function automatic logic [KernW-1:0] gauss_q15(logic [AccW-1:0] d);
    logic [63:0] x;
    logic [63:0] p;
    x = 64'(gamma_q) * 64'(d[47:24]) + ((64'(gamma_q) * 64'(d[23:0])) >> 24);
    if (x >= 64'(1 << 20)) return '0;
    p = 64'd1 << 30;
    for (int k = 0; k < 20; k++)
      if (x[k]) p = (p * 64'(ExpStep[k]) + (64'd1 << 29)) >> 30;
    return KernW'((p + (64'd1 << 14)) >> 15);
  endfunction

  task automatic predict_beat(beat_t b);
    int n;
    int diff;
    logic [63:0] mag;
    logic [63:0] sq;
    logic [63:0] sum;
    kernel_res_t r;
    if (b.cmd == CMD_LOAD) begin
      // row_end has no effect on loads
      center_mem[b.slot][b.fidx] = b.val;
      loaded[b.slot][b.fidx] = 1'b1;
      return;
    end
    n = active_centers();
    for (int c = 0; c < n; c++) begin
      diff = int'(b.val) - int'(center_mem[c][b.fidx]);
      mag = 64'(diff < 0 ? -diff : diff);
      sq = (mag >= 64'(1 << 24)) ? 64'(AccMax) : mag * mag;
      sum = 64'(dist_acc[c]) + sq;
      dist_acc[c] = (sum > 64'(AccMax) || sq == 64'(AccMax)) ? AccMax : sum[AccW-1:0];
    end
    if (!b.rend) return;
    // count at row end picks the emitted centers; all accumulators clear
    for (int c = 0; c < n; c++) begin
      r.num = SlotW'(c);
      r.kv = b.typed ? b.kv : gauss_q15(dist_acc[c]);
      r.last = (c == n - 1);
      pending_kernels.push_back(r);
    end
    for (int c = 0; c < NumCenters; c++) dist_acc[c] = '0;
  endtask

  // ---------------- drivers ----------------

  task automatic send_beat(beat_t b);
    if (!quiet && $urandom_range(99) < 10) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_command <= b.cmd;
    in_center_slot <= b.slot;
    in_feature_index <= b.fidx;
    in_feature_value <= b.val;
    in_row_end <= b.rend;
    // beat taken at the first edge with busy low
    do @(posedge clk); while (busy);
    predict_beat(b);
  endtask

  task automatic write_reg(logic idx, logic [GammaW-1:0] data);
    start <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GAMMA) gamma_q = data;
    else count_q = data[CountW-1:0];
  endtask

  // all kernels delivered, then let any trailing data beat settle
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_kernels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // ---------------- stimulus helpers ----------------

  // values near a loaded center 0 feature, extremes and plain random
  function automatic logic signed [15:0] pick_value();
    int f;
    logic signed [15:0] base;
    f = $urandom_range(63);
    base = loaded[0][f] ? center_mem[0][f] : 16'sh0000;
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      3: return -16'sd1;
      4, 5, 6: return base + 16'($urandom_range(0, 2048)) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic beat_t random_load();
    beat_t b;
    int fi;
    int slot;
    int targets [5];
    targets = '{0, 1, 2, 63, $urandom_range(63)};
    fi = targets[$urandom_range(4)];
    slot = $urandom_range(NumCenters - 1);
    // mostly fill the first gap so whole feature columns become readable
    if ($urandom_range(3) != 0)
      for (int c = NumCenters - 1; c >= 0; c--)
        if (!loaded[c][fi]) slot = c;
    b.cmd = CMD_LOAD;
    b.slot = SlotW'(slot);
    b.fidx = FidxW'(fi);
    b.val = pick_value();
    b.rend = 1'($urandom);
    b.typed = 1'b0;
    b.kv = '0;
    return b;
  endfunction

  // a data beat only touches columns loaded for every active center
  function automatic beat_t random_beat();
    beat_t b;
    int ready_cols[$];
    int n;
    bit ok;
    n = active_centers();
    for (int f = 0; f < NumFeatures; f++) begin
      ok = 1'b1;
      for (int c = 0; c < n; c++) if (!loaded[c][f]) ok = 1'b0;
      if (ok) ready_cols.push_back(f);
    end
    if (ready_cols.size() == 0 || $urandom_range(9) < 3) return random_load();
    b.cmd = CMD_DATA;
    b.slot = SlotW'($urandom);
    b.fidx = FidxW'(ready_cols[$urandom_range(ready_cols.size() - 1)]);
    b.val = pick_value();
    b.rend = ($urandom_range(3) == 0);
    b.typed = 1'b0;
    b.kv = '0;
    return b;
  endfunction

  // ---------------- directed table ----------------
  // run with one center in use; typed kernels are exact: zero distance gives 1.0,
  // a full-scale difference drives the exponent past the table and gives 0
  beat_t directed_rows [12] = '{
    '{CMD_LOAD, 5'd0,  6'd0,  16'sh0000, 1'b0, 1'b0, 16'd0},
    '{CMD_DATA, 5'd0,  6'd0,  16'sh0000, 1'b1, 1'b1, 16'd32768},
    '{CMD_LOAD, 5'd0,  6'd63, 16'sh8000, 1'b0, 1'b0, 16'd0},
    '{CMD_DATA, 5'd31, 6'd63, 16'sh7FFF, 1'b1, 1'b1, 16'd0},
    '{CMD_LOAD, 5'd0,  6'd1,  16'sh0064, 1'b1, 1'b0, 16'd0},  // load with row end
    '{CMD_DATA, 5'd0,  6'd1,  16'sh0064, 1'b0, 1'b0, 16'd0},
    '{CMD_DATA, 5'd0,  6'd0,  16'sh0000, 1'b1, 1'b1, 16'd32768},
    '{CMD_DATA, 5'd21, 6'd1,  16'sh1064, 1'b1, 1'b0, 16'd0},  // distance 1.0
    '{CMD_DATA, 5'd0,  6'd0,  -16'sd1,   1'b1, 1'b0, 16'd0},
    '{CMD_LOAD, 5'd31, 6'd42, 16'sh7FFF, 1'b0, 1'b0, 16'd0},
    '{CMD_LOAD, 5'd10, 6'd21, 16'sh5555, 1'b0, 1'b0, 16'd0},
    '{CMD_DATA, 5'd10, 6'd63, 16'sh8000, 1'b1, 1'b1, 16'd32768}
  };

  // ---------------- result check ----------------

  always @(posedge clk) begin
    kernel_res_t e;
    if (rst_n && out_valid) begin
      if (pending_kernels.size() == 0) begin
        $error("kernel result with none expected: center %0d value %0d",
               out_center_number, out_kernel_value);
        errors++;
      end else begin
        e = pending_kernels.pop_front();
        if (out_center_number !== e.num) begin
          $error("center_number: expected %0d, got %0d", e.num, out_center_number);
          errors++;
        end
        if (out_kernel_value !== e.kv) begin
          $error("kernel_value: expected %0d, got %0d", e.kv, out_kernel_value);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // watchdog: any beat on any channel resets the count
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= StallLimit) begin
      $display("rbf_kernel_row_engine_tb failed");
      $finish;
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    logic [GammaW-1:0] phase_gamma [8];
    logic [GammaW-1:0] phase_count [8];
    gamma_q = 24'd65536;
    count_q = 6'd32;
    for (int c = 0; c < NumCenters; c++) dist_acc[c] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part: one center, default gamma of 1.0
    write_reg(REG_COUNT, 24'd1);
    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    wait_drained();

    // random phases sweep gamma and count, extremes included; count 0 and 63
    // clamp to one and all centers
    phase_gamma = '{24'd1, 24'd0, 24'd256, 24'hFFFFFF, 24'd4096, 24'd65536, 24'd16,
                    24'($urandom)};
    phase_count = '{24'd2, 24'd0, 24'd32, 24'd5, 24'd63, 24'd17, 24'd32,
                    24'($urandom_range(1, 32))};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_GAMMA, phase_gamma[ph]);
      write_reg(REG_COUNT, phase_count[ph]);
      quiet = (ph == 3);  // one long stretch with no gaps
      for (int i = 0; i < 25; i++) send_beat(random_beat());
      wait_drained();
    end

    if (errors == 0)
      $display("rbf_kernel_row_engine_tb passed");
    else
      $display("rbf_kernel_row_engine_tb failed");
    $finish;
  end
endmodule
